// File: rtl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, codes and helpers of the hex record line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_MALFORMED    = 3'd1,
        ST_CHECKSUM     = 3'd2,
        ST_LENGTH       = 3'd3,
        ST_OFFSET       = 3'd4,
        ST_TYPE_LEN     = 3'd5,
        ST_UNKNOWN_TYPE = 3'd6
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [8:0] HDR_BYTES   = 9'd4;
    localparam logic [8:0] FRAME_BYTES = 9'd5;
    localparam logic [8:0] COUNT_MAX   = 9'd511;
    localparam logic [7:0] TYPE_MAX    = 8'd5;

    localparam logic [8:0] POS_LENGTH  = 9'd0;
    localparam logic [8:0] POS_ADDR_HI = 9'd1;
    localparam logic [8:0] POS_ADDR_LO = 9'd2;
    localparam logic [8:0] POS_TYPE    = 9'd3;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } nibble_t;

    typedef struct packed {
        logic        emit;
        logic        last;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        status_t     status;
        logic [7:0]  record_type;
        logic [15:0] load_offset;
        logic [7:0]  data_count;
    } line_evt_t;

    function automatic nibble_t hex_value(input logic [7:0] c);
        nibble_t n;
        n.valid = 1'b0;
        n.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n.valid = 1'b1;
            n.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            n.valid = 1'b1;
            n.value = c[3:0] + 4'd9;
        end
        return n;
    endfunction

    function automatic logic [7:0] type_len(input logic [7:0] t);
        logic [7:0] len;
        unique case (t)
            8'd2:    len = 8'd2;
            8'd3:    len = 8'd4;
            8'd4:    len = 8'd2;
            8'd5:    len = 8'd4;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/hrlp_if.sv
// ----------------------------------------------------------------------------
// hrlp channel interfaces
// Character input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrlp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface hrlp_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [2:0]  status;
    logic [7:0]  record_type;
    logic [15:0] load_offset;
    logic [7:0]  data_count;

    modport source (
        output valid, output result_kind, output data_byte, output byte_index,
        output status, output record_type, output load_offset, output data_count,
        input  ready
    );
    modport sink (
        input  valid, input result_kind, input data_byte, input byte_index,
        input  status, input record_type, input load_offset, input data_count,
        output ready
    );
endinterface

// File: rtl/hex_record_line_parser.sv
// ----------------------------------------------------------------------------
// hex_record_line_parser
// Parses Intel HEX record lines one character per transaction.
//
// chars:   sink channel, one ASCII character per transaction; line_end marks
//          the last character of a line. The first character must be ':'.
// results: source channel. A data transaction (result_kind 0) carries each
//          payload byte as it is decoded, provisional until the line status.
//          A status transaction (result_kind 1) follows the last character
//          with status, record type, load offset and record length.
// Output: each result is registered and appears in the cycle after the character that causes it.
// Throughput: one character per cycle while chars is not stalled; the line state update and
//          checks fit between the input handshake and the result register.
// Stall: the result register holds until taken; a new character is
//          accepted in the same cycle the held result leaves, and chars
//          stalls only while a result waits and results.ready is low.
// Reset: clears line state and the result valid flag; the next character opens a line.
// ----------------------------------------------------------------------------
module hex_record_line_parser (
    input  logic          clk,
    input  logic          rst_n,
    hrlp_char_if.sink     chars,
    hrlp_result_if.source results
);

    hrlp_pkg::line_evt_t evt;
    logic accept;
    logic produce;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [7:0]  data_reg;
    logic [7:0]  index_reg;
    logic [2:0]  status_reg;
    logic [7:0]  type_reg;
    logic [15:0] offset_reg;
    logic [7:0]  count_reg;

    assign chars.ready = !out_valid_reg || results.ready;
    assign accept      = chars.valid && chars.ready;
    assign produce     = accept && (evt.last || evt.emit);

    hrlp_line_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (chars.char_code),
        .line_end  (chars.line_end),
        .evt       (evt)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            if (evt.last)
            begin
                kind_reg   <= hrlp_pkg::KIND_STATUS;
                data_reg   <= 8'd0;
                index_reg  <= 8'd0;
                status_reg <= evt.status;
                type_reg   <= evt.record_type;
                offset_reg <= evt.load_offset;
                count_reg  <= evt.data_count;
            end
            else
            begin
                kind_reg   <= hrlp_pkg::KIND_DATA;
                data_reg   <= evt.data_byte;
                index_reg  <= evt.byte_index;
                status_reg <= hrlp_pkg::ST_OK;
                type_reg   <= 8'd0;
                offset_reg <= 16'd0;
                count_reg  <= 8'd0;
            end
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.result_kind = kind_reg;
    assign results.data_byte   = data_reg;
    assign results.byte_index  = index_reg;
    assign results.status      = status_reg;
    assign results.record_type = type_reg;
    assign results.load_offset = offset_reg;
    assign results.data_count  = count_reg;

endmodule

// File: rtl/hrlp_line_tracker.sv
// ----------------------------------------------------------------------------
// hrlp_line_tracker
// Per-line state: hex pairing, header capture, checksum and status checks.
// ----------------------------------------------------------------------------
module hrlp_line_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         char_code,
    input  logic               line_end,
    output hrlp_pkg::line_evt_t evt
);

    logic        in_line_reg,  in_line_next;
    logic        bad_reg,      bad_next;
    logic        pending_reg,  pending_next;
    logic [3:0]  high_reg,     high_next;
    logic [8:0]  seen_reg,     seen_next;
    logic [7:0]  sum_reg,      sum_next;
    logic [7:0]  len_reg,      len_next;
    logic [15:0] offset_reg,   offset_next;
    logic [7:0]  type_reg,     type_next;

    hrlp_pkg::nibble_t nib;
    logic       complete;
    logic [7:0] cur_byte;
    logic [8:0] idx;

    always_comb
    begin
        nib          = hrlp_pkg::hex_value(char_code);
        in_line_next = in_line_reg;
        bad_next     = bad_reg;
        pending_next = pending_reg;
        high_next    = high_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        len_next     = len_reg;
        offset_next  = offset_reg;
        type_next    = type_reg;
        complete     = 1'b0;
        cur_byte     = {high_reg, nib.value};

        if (!in_line_reg)
        begin
            in_line_next = 1'b1;
            bad_next     = (char_code != hrlp_pkg::CHAR_COLON);
            pending_next = 1'b0;
            high_next    = 4'd0;
            seen_next    = 9'd0;
            sum_next     = 8'd0;
            len_next     = 8'd0;
            offset_next  = 16'd0;
            type_next    = 8'd0;
        end
        else if (!nib.valid)
        begin
            bad_next = 1'b1;
        end
        else if (!pending_reg)
        begin
            high_next    = nib.value;
            pending_next = 1'b1;
        end
        else
        begin
            pending_next = 1'b0;
            complete     = 1'b1;
            sum_next     = sum_reg + cur_byte;
            unique case (seen_reg)
                hrlp_pkg::POS_LENGTH:  len_next          = cur_byte;
                hrlp_pkg::POS_ADDR_HI: offset_next[15:8] = cur_byte;
                hrlp_pkg::POS_ADDR_LO: offset_next[7:0]  = cur_byte;
                hrlp_pkg::POS_TYPE:    type_next         = cur_byte;
                default: ;
            endcase
            if (seen_reg != hrlp_pkg::COUNT_MAX)
                seen_next = seen_reg + 9'd1;
        end

        if (line_end)
            in_line_next = 1'b0;
    end

    always_comb
    begin
        idx            = seen_reg - hrlp_pkg::HDR_BYTES;
        evt.emit       = complete && !line_end && (seen_reg >= hrlp_pkg::HDR_BYTES);
        evt.last       = line_end;
        evt.data_byte  = cur_byte;
        evt.byte_index = idx[8] ? 8'd255 : idx[7:0];
        evt.record_type = type_next;
        evt.load_offset = offset_next;
        evt.data_count  = len_next;

        if (bad_next || pending_next || seen_next == 9'd0)
            evt.status = hrlp_pkg::ST_MALFORMED;
        else if (sum_next != 8'd0)
            evt.status = hrlp_pkg::ST_CHECKSUM;
        else if (seen_next != ({1'b0, len_next} + hrlp_pkg::FRAME_BYTES))
            evt.status = hrlp_pkg::ST_LENGTH;
        else if (type_next == 8'd0)
            evt.status = hrlp_pkg::ST_OK;
        else if (type_next > hrlp_pkg::TYPE_MAX)
            evt.status = hrlp_pkg::ST_UNKNOWN_TYPE;
        else if (offset_next != 16'd0)
            evt.status = hrlp_pkg::ST_OFFSET;
        else if (len_next != hrlp_pkg::type_len(type_next))
            evt.status = hrlp_pkg::ST_TYPE_LEN;
        else
            evt.status = hrlp_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg <= 1'b0;
            bad_reg     <= 1'b0;
            pending_reg <= 1'b0;
            high_reg    <= 4'd0;
            seen_reg    <= 9'd0;
            sum_reg     <= 8'd0;
            len_reg     <= 8'd0;
            offset_reg  <= 16'd0;
            type_reg    <= 8'd0;
        end
        else if (accept)
        begin
            in_line_reg <= in_line_next;
            bad_reg     <= bad_next;
            pending_reg <= pending_next;
            high_reg    <= high_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            len_reg     <= len_next;
            offset_reg  <= offset_next;
            type_reg    <= type_next;
        end
    end

endmodule
